@@ hdl/shell_line_tokenizer_core_assert.svh @@
// Assertion macros for the line tokenizer core.
// The expanding module must have i_clk and i_rst_n in scope.
`ifndef SHELL_LINE_TOKENIZER_CORE_ASSERT_SVH
`define SHELL_LINE_TOKENIZER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define SLT_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);
`define SLT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SLT_ASSERT_ALWAYS(lbl, cond, msg)
`define SLT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ hdl/slt_pkg.sv @@
// ----------------------------------------------------------------------------
// slt_pkg
// Types, constants and helpers shared by the line tokenizer core.
// ----------------------------------------------------------------------------
package slt_pkg;

    localparam int LINE_MAX_BYTES = 4096;
    localparam int POS_W          = $clog2(LINE_MAX_BYTES + 1);
    localparam int OFS_W          = 12;
    localparam int LEN_W          = 12;
    localparam int TYPE_W         = 4;
    localparam int QUOTE_W        = 2;

    localparam int RES_DEPTH  = 4;
    localparam int RES_PTR_W  = $clog2(RES_DEPTH);
    localparam int RES_CNT_W  = $clog2(RES_DEPTH + 1);

    localparam logic [LEN_W-1:0] LEN_SAT = '1;

    localparam logic [7:0] CH_PIPE   = 8'h7C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] WS_LO     = 8'd8;
    localparam logic [7:0] WS_HI     = 8'd14;

    typedef enum logic [2:0] {
        SCAN_IDLE,
        SCAN_WORD,
        SCAN_SQ,
        SCAN_DQ,
        SCAN_GT,
        SCAN_LT
    } t_scan_mode;

    typedef enum logic [QUOTE_W-1:0] {
        QUOTE_NONE,
        QUOTE_SINGLE,
        QUOTE_DOUBLE
    } t_quote;

    typedef enum logic [TYPE_W-1:0] {
        TOK_WORD,
        TOK_PIPE,
        TOK_IN,
        TOK_OUT,
        TOK_APPEND,
        TOK_HEREDOC,
        TOK_IN_TGT,
        TOK_OUT_TGT,
        TOK_APPEND_TGT,
        TOK_HEREDOC_TGT,
        TOK_LINE_END
    } t_tok_type;

    typedef struct packed {
        t_scan_mode       mode;
        t_quote           quote;
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] start;
        logic             redir_pend;
        logic [1:0]       redir_kind;
        logic             ovf;
    } t_tok_state;

    // raw token before retyping and formatting
    typedef struct packed {
        logic             vld;
        t_tok_type        ttype;
        logic [POS_W-1:0] start;
        logic [POS_W-1:0] len;
        t_quote           quote;
    } t_emit;

    typedef struct packed {
        logic [TYPE_W-1:0]  token_type;
        logic [OFS_W-1:0]   token_start;
        logic [LEN_W-1:0]   token_length;
        logic [QUOTE_W-1:0] quote_state;
        logic               line_error;
        logic               last_of_run;
    } t_result;

    typedef struct packed {
        logic [RES_CNT_W-1:0] count;
        logic                 room2;
        logic                 empty;
    } t_fifo_status;

    function automatic logic is_word_byte(input logic [7:0] b);
        logic sep;
        sep = (b == CH_PIPE) || (b == CH_GT) || (b == CH_LT) || (b == CH_DOLLAR) ||
              (b == CH_SQUOTE) || (b == CH_DQUOTE) || (b == CH_SPACE) ||
              (b == CH_NUL) || ((b > WS_LO) && (b < WS_HI));
        return !sep;
    endfunction

    function automatic t_emit mk_emit(input t_tok_type ttype, input logic [POS_W-1:0] start,
                                      input logic [POS_W-1:0] len, input t_quote quote);
        t_emit e;
        e.vld   = 1'b1;
        e.ttype = ttype;
        e.start = start;
        e.len   = len;
        e.quote = quote;
        return e;
    endfunction

    function automatic logic [LEN_W-1:0] sat_len(input logic [POS_W-1:0] len);
        logic [LEN_W-1:0] r;
        r = LEN_W'(len);
        if (POS_W > LEN_W) begin
            if (len > POS_W'(LEN_SAT)) begin
                r = LEN_SAT;
            end
        end
        return r;
    endfunction

endpackage

@@ hdl/slt_if.sv @@
// ----------------------------------------------------------------------------
// slt_in_if / slt_out_if
// Valid/ready channels carrying line bytes in and tokens out.
// ----------------------------------------------------------------------------
interface slt_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] char_byte;

    modport source (output valid, output kind, output char_byte, input ready);
    modport sink   (input valid, input kind, input char_byte, output ready);
endinterface

interface slt_out_if;
    import slt_pkg::*;
    logic               valid;
    logic               ready;
    logic [TYPE_W-1:0]  token_type;
    logic [OFS_W-1:0]   token_start;
    logic [LEN_W-1:0]   token_length;
    logic [QUOTE_W-1:0] quote_state;
    logic               line_error;
    logic               last_of_run;

    modport source (output valid, output token_type, output token_start, output token_length,
                    output quote_state, output line_error, output last_of_run, input ready);
    modport sink   (input valid, input token_type, input token_start, input token_length,
                    input quote_state, input line_error, input last_of_run, output ready);
endinterface

@@ hdl/shell_line_tokenizer_core.sv @@
// Each beat passes the input register, its tokens the token queue. Throughput: one input
// beat per cycle; the queue drains one beat per cycle while the receiver is ready, so
// items that close two tokens (word then pipe, line end after an open token) fill two
// entries. The input register stalls only when the 4-entry queue has room for fewer than two.
// Reset (synchronous, active low) returns the scanner to between tokens at offset zero.
// ----------------------------------------------------------------------------
// shell_line_tokenizer_core
// Streaming command-line tokenizer: bytes in, word/pipe/redirection/line-end tokens out.
// ----------------------------------------------------------------------------
`include "shell_line_tokenizer_core_assert.svh"

module shell_line_tokenizer_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    slt_in_if.sink    i_in,
    slt_out_if.source o_out
);
    import slt_pkg::*;

    logic         r_in_vld;
    logic         r_kind;
    logic [7:0]   r_byte;
    t_tok_state   r_state;
    t_tok_state   n_state;
    t_result      step_res [2];
    logic [1:0]   step_cnt;
    logic         step_fire;
    t_result      head;
    t_fifo_status fifo_st;
    logic         pop;
    logic         line_end_fire;
    logic         scan_clear;

    assign step_fire  = r_in_vld && fifo_st.room2;
    assign i_in.ready = !r_in_vld || step_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_vld <= 1'b1;
        end else if (step_fire) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_kind <= i_in.kind;
            r_byte <= i_in.char_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (step_fire) begin
            r_state <= n_state;
        end
    end

    slt_step u_step (
        .i_state   (r_state),
        .i_kind    (r_kind),
        .i_byte    (r_byte),
        .o_state   (n_state),
        .o_res     (step_res),
        .o_res_cnt (step_cnt)
    );

    slt_res_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push_cnt  (step_fire ? step_cnt : 2'd0),
        .i_push_data (step_res),
        .i_pop       (pop),
        .o_head      (head),
        .o_status    (fifo_st)
    );

    assign pop                = o_out.valid && o_out.ready;
    assign o_out.valid        = !fifo_st.empty;
    assign o_out.token_type   = head.token_type;
    assign o_out.token_start  = head.token_start;
    assign o_out.token_length = head.token_length;
    assign o_out.quote_state  = head.quote_state;
    assign o_out.line_error   = head.line_error;
    assign o_out.last_of_run  = head.last_of_run;

    assign line_end_fire = step_fire && r_kind;
    assign scan_clear    = (r_state.mode == SCAN_IDLE) && (r_state.pos == '0) &&
                           !r_state.redir_pend;

    `SLT_ASSERT_ALWAYS(a_fifo_bound, fifo_st.count <= RES_CNT_W'(RES_DEPTH), "queue overrun")
    `SLT_ASSERT_ALWAYS(a_pos_bound, r_state.pos <= POS_W'(LINE_MAX_BYTES), "position overrun")
    `SLT_ASSERT_NEXT(a_line_end_clear, line_end_fire, scan_clear, "state kept past line end")

endmodule

@@ hdl/slt_step.sv @@
// ----------------------------------------------------------------------------
// slt_step
// Per-beat tokenizer update (byte or line end): next scan state and up to two tokens.
// ----------------------------------------------------------------------------
module slt_step (
    input  slt_pkg::t_tok_state i_state,
    input  logic                i_kind,
    input  logic [7:0]          i_byte,
    output slt_pkg::t_tok_state o_state,
    output slt_pkg::t_result    o_res [2],
    output logic [1:0]          o_res_cnt
);
    import slt_pkg::*;

    t_tok_state n_base;
    t_emit      raw [2];
    logic       line_end;
    logic       end_err;
    logic       n_pend;
    logic [1:0] n_kind;

    // next state and raw token requests
    always_comb begin
        logic [POS_W-1:0] p;
        logic             do_idle;
        n_base   = i_state;
        raw[0]   = '0;
        raw[1]   = '0;
        line_end = 1'b0;
        end_err  = 1'b0;
        p        = i_state.pos;
        do_idle  = 1'b0;
        if (!i_kind) begin
            if (i_state.pos >= POS_W'(LINE_MAX_BYTES)) begin
                n_base.ovf = 1'b1;
            end else begin
                n_base.pos = p + POS_W'(1);
                unique case (i_state.mode)
                    SCAN_WORD: begin
                        if (!is_word_byte(i_byte)) begin
                            raw[0] = mk_emit(TOK_WORD, i_state.start, p - i_state.start,
                                             i_state.quote);
                            n_base.mode = SCAN_IDLE;
                            do_idle     = 1'b1;
                        end
                    end
                    SCAN_SQ, SCAN_DQ: begin
                        if ((i_state.mode == SCAN_SQ && i_byte == CH_SQUOTE) ||
                            (i_state.mode == SCAN_DQ && i_byte == CH_DQUOTE)) begin
                            raw[0] = mk_emit(TOK_WORD, i_state.start, p - i_state.start,
                                             i_state.quote);
                            n_base.mode = SCAN_IDLE;
                        end
                    end
                    SCAN_GT, SCAN_LT: begin
                        n_base.mode = SCAN_IDLE;
                        if ((i_state.mode == SCAN_GT && i_byte == CH_GT) ||
                            (i_state.mode == SCAN_LT && i_byte == CH_LT)) begin
                            raw[0] = mk_emit((i_state.mode == SCAN_GT) ? TOK_APPEND : TOK_HEREDOC,
                                             i_state.start, POS_W'(2), i_state.quote);
                        end else begin
                            raw[0] = mk_emit((i_state.mode == SCAN_GT) ? TOK_OUT : TOK_IN,
                                             i_state.start, POS_W'(1), i_state.quote);
                            do_idle = 1'b1;
                        end
                    end
                    default: begin
                        n_base.mode = SCAN_IDLE;
                        do_idle     = 1'b1;
                    end
                endcase

                if (do_idle) begin
                    // quote mode only moves at a token start
                    if (i_byte == CH_SQUOTE && i_state.quote == QUOTE_NONE) begin
                        n_base.quote = QUOTE_SINGLE;
                    end else if (i_byte == CH_DQUOTE && i_state.quote == QUOTE_NONE) begin
                        n_base.quote = QUOTE_DOUBLE;
                    end else if (i_byte == CH_SQUOTE && i_state.quote == QUOTE_SINGLE) begin
                        n_base.quote = QUOTE_NONE;
                    end else if (i_byte == CH_DQUOTE && i_state.quote == QUOTE_DOUBLE) begin
                        n_base.quote = QUOTE_NONE;
                    end

                    if (is_word_byte(i_byte)) begin
                        n_base.start = p;
                        n_base.mode  = SCAN_WORD;
                    end else if (i_byte == CH_PIPE) begin
                        raw[1] = mk_emit(TOK_PIPE, p, POS_W'(1), n_base.quote);
                    end else if (i_byte == CH_GT) begin
                        n_base.start = p;
                        n_base.mode  = SCAN_GT;
                    end else if (i_byte == CH_LT) begin
                        n_base.start = p;
                        n_base.mode  = SCAN_LT;
                    end else if (i_byte == CH_SQUOTE) begin
                        n_base.start = p + POS_W'(1);
                        n_base.mode  = SCAN_SQ;
                    end else if (i_byte == CH_DQUOTE) begin
                        n_base.start = p + POS_W'(1);
                        n_base.mode  = SCAN_DQ;
                    end
                end
            end
        end else begin
            line_end = 1'b1;
            end_err  = i_state.ovf;
            unique case (i_state.mode)
                SCAN_WORD: raw[0] = mk_emit(TOK_WORD, i_state.start, p - i_state.start,
                                            i_state.quote);
                SCAN_GT:   raw[0] = mk_emit(TOK_OUT, i_state.start, POS_W'(1), i_state.quote);
                SCAN_LT:   raw[0] = mk_emit(TOK_IN, i_state.start, POS_W'(1), i_state.quote);
                SCAN_SQ, SCAN_DQ: end_err = 1'b1;
                default: ;
            endcase
            // line end token rides in the second slot, never retyped
            raw[1] = mk_emit(TOK_LINE_END, p, '0, QUOTE_NONE);
            n_base = '0;
        end
    end

    // retyping, formatting and packing of results
    always_comb begin
        t_result   fmt [2];
        t_tok_type tt;
        logic      pend;
        logic [1:0] kind;
        pend = i_state.redir_pend;
        kind = i_state.redir_kind;
        for (int i = 0; i < 2; i++) begin
            tt = raw[i].ttype;
            if (raw[i].vld && !(line_end && i == 1)) begin
                if (pend) begin
                    tt   = t_tok_type'(TYPE_W'(TOK_IN_TGT) + TYPE_W'(kind));
                    pend = 1'b0;
                end else if (tt == TOK_IN || tt == TOK_OUT || tt == TOK_APPEND ||
                             tt == TOK_HEREDOC) begin
                    pend = 1'b1;
                    kind = 2'(TYPE_W'(tt) - TYPE_W'(TOK_IN));
                end
            end
            fmt[i].token_type   = TYPE_W'(tt);
            fmt[i].token_start  = OFS_W'(raw[i].start);
            fmt[i].token_length = sat_len(raw[i].len);
            fmt[i].quote_state  = QUOTE_W'(raw[i].quote);
            fmt[i].line_error   = line_end && (i == 1) && end_err;
            fmt[i].last_of_run  = 1'b0;
        end
        n_pend = line_end ? 1'b0 : pend;
        n_kind = line_end ? 2'b00 : kind;

        if (raw[0].vld) begin
            o_res[0]  = fmt[0];
            o_res[1]  = fmt[1];
            o_res_cnt = raw[1].vld ? 2'd2 : 2'd1;
            if (raw[1].vld) begin
                o_res[1].last_of_run = 1'b1;
            end else begin
                o_res[0].last_of_run = 1'b1;
            end
        end else begin
            o_res[0]  = fmt[1];
            o_res[1]  = fmt[1];
            o_res_cnt = raw[1].vld ? 2'd1 : 2'd0;
            o_res[0].last_of_run = 1'b1;
        end
    end

    always_comb begin
        o_state            = n_base;
        o_state.redir_pend = n_pend;
        o_state.redir_kind = n_kind;
    end

endmodule

@@ hdl/slt_res_fifo.sv @@
// ----------------------------------------------------------------------------
// slt_res_fifo
// Small token queue: takes up to two tokens per cycle, hands out one.
// ----------------------------------------------------------------------------
module slt_res_fifo (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [1:0]            i_push_cnt,
    input  slt_pkg::t_result      i_push_data [2],
    input  logic                  i_pop,
    output slt_pkg::t_result      o_head,
    output slt_pkg::t_fifo_status o_status
);
    import slt_pkg::*;

    t_result              r_mem [RES_DEPTH];
    logic [RES_PTR_W-1:0] r_wr_ptr;
    logic [RES_PTR_W-1:0] r_rd_ptr;
    logic [RES_CNT_W-1:0] r_count;
    logic [RES_CNT_W-1:0] n_count;

    assign n_count = r_count + RES_CNT_W'(i_push_cnt) - RES_CNT_W'(i_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + RES_PTR_W'(i_push_cnt);
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + RES_PTR_W'(1);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push_data[0];
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[r_wr_ptr + RES_PTR_W'(1)] <= i_push_data[1];
        end
    end

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.count = r_count;
    assign o_status.room2 = (r_count <= RES_CNT_W'(RES_DEPTH - 2));
    assign o_status.empty = (r_count == '0);

endmodule

@@ tb/sv/tb_shell_line_tokenizer_core.sv @@
// ----------------------------------------------------------------------------
// tb_shell_line_tokenizer_core
// Self-checking bench for the line tokenizer: byte beats and line ends go in,
// a behavioral tokenizer predicts every token, and each output beat is
// compared field by field against the oldest pending token.
// ----------------------------------------------------------------------------
module tb_shell_line_tokenizer_core;
    timeunit 1ns;
    timeprecision 1ps;

    import slt_pkg::*;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam int CYCLE_LIMIT = 1_000_000;

    // receiver stall patterns
    localparam int RX_ALWAYS = 0;
    localparam int RX_RANDOM = 1;
    localparam int RX_RUNS   = 2;

    logic i_clk;
    logic i_rst_n;

    slt_in_if  in_ch();
    slt_out_if out_ch();

    shell_line_tokenizer_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // predicted tokenizer state
    t_scan_mode       scan_st;
    t_quote           quote_st;
    logic [POS_W-1:0] line_pos;
    logic [POS_W-1:0] tok_start;
    logic             retarget_pend;
    logic [1:0]       retarget_kind;
    logic             line_ovf;

    t_result pending_tokens[$];
    int      beat_tokens;

    int  error_count;
    int  cycle_count;
    int  beats_sent;
    bit  tx_bursty;
    int  burst_left;
    int  rx_style;
    int  rx_run;
    bit  rx_level;

    t_result got_tok;
    t_result want_tok;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // token predictor
    // ------------------------------------------------------------------------
    function automatic bit plain_byte(input logic [7:0] b);
        if (b == CH_PIPE || b == CH_GT || b == CH_LT || b == CH_DOLLAR ||
            b == CH_SQUOTE || b == CH_DQUOTE || b == CH_SPACE || b == CH_NUL)
            return 1'b0;
        if (b > WS_LO && b < WS_HI)
            return 1'b0;
        return 1'b1;
    endfunction

    function automatic void clear_line_state();
        scan_st       = SCAN_IDLE;
        quote_st      = QUOTE_NONE;
        line_pos      = '0;
        tok_start     = '0;
        retarget_pend = 1'b0;
        retarget_kind = 2'd0;
        line_ovf      = 1'b0;
    endfunction

    function automatic void push_token(input t_tok_type ttype, input logic [POS_W-1:0] start,
                                       input logic [POS_W-1:0] len);
        t_tok_type t;
        t_result   r;
        t = ttype;
        if (retarget_pend) begin
            t = t_tok_type'(TOK_IN_TGT + retarget_kind);
            retarget_pend = 1'b0;
        end else if (ttype >= TOK_IN && ttype <= TOK_HEREDOC) begin
            retarget_pend = 1'b1;
            retarget_kind = 2'(ttype - TOK_IN);
        end
        r.token_type   = t;
        r.token_start  = start[OFS_W-1:0];
        r.token_length = (len > POS_W'(4095)) ? {LEN_W{1'b1}} : len[LEN_W-1:0];
        r.quote_state  = quote_st;
        r.line_error   = 1'b0;
        r.last_of_run  = 1'b0;
        pending_tokens.push_back(r);
        beat_tokens++;
    endfunction

    // a byte seen between tokens: quote mode moves, then a token may open
    function automatic void open_token(input logic [7:0] b, input logic [POS_W-1:0] p);
        if (b == CH_SQUOTE && quote_st == QUOTE_NONE)
            quote_st = QUOTE_SINGLE;
        else if (b == CH_DQUOTE && quote_st == QUOTE_NONE)
            quote_st = QUOTE_DOUBLE;
        else if (b == CH_SQUOTE && quote_st == QUOTE_SINGLE)
            quote_st = QUOTE_NONE;
        else if (b == CH_DQUOTE && quote_st == QUOTE_DOUBLE)
            quote_st = QUOTE_NONE;

        if (plain_byte(b)) begin
            tok_start = p;
            scan_st   = SCAN_WORD;
        end else if (b == CH_PIPE) begin
            push_token(TOK_PIPE, p, POS_W'(1));
        end else if (b == CH_GT) begin
            tok_start = p;
            scan_st   = SCAN_GT;
        end else if (b == CH_LT) begin
            tok_start = p;
            scan_st   = SCAN_LT;
        end else if (b == CH_SQUOTE) begin
            tok_start = p + 1'b1;
            scan_st   = SCAN_SQ;
        end else if (b == CH_DQUOTE) begin
            tok_start = p + 1'b1;
            scan_st   = SCAN_DQ;
        end
    endfunction

    function automatic void take_line_byte(input logic [7:0] b);
        logic [POS_W-1:0] p;
        bit               is_gt;
        p = line_pos;
        if (p >= POS_W'(LINE_MAX_BYTES)) begin
            line_ovf = 1'b1;
            return;
        end
        line_pos = p + 1'b1;
        case (scan_st)
            SCAN_WORD: begin
                if (plain_byte(b))
                    return;
                push_token(TOK_WORD, tok_start, p - tok_start);
                scan_st = SCAN_IDLE;
            end
            SCAN_SQ, SCAN_DQ: begin
                if ((scan_st == SCAN_SQ && b == CH_SQUOTE) ||
                    (scan_st == SCAN_DQ && b == CH_DQUOTE)) begin
                    push_token(TOK_WORD, tok_start, p - tok_start);
                    scan_st = SCAN_IDLE;
                end
                return;
            end
            SCAN_GT, SCAN_LT: begin
                is_gt   = (scan_st == SCAN_GT);
                scan_st = SCAN_IDLE;
                if (b == (is_gt ? CH_GT : CH_LT)) begin
                    push_token(is_gt ? TOK_APPEND : TOK_HEREDOC, tok_start, POS_W'(2));
                    return;
                end
                push_token(is_gt ? TOK_OUT : TOK_IN, tok_start, POS_W'(1));
            end
            default: scan_st = SCAN_IDLE;
        endcase
        open_token(b, p);
    endfunction

    function automatic void take_line_end();
        t_result r;
        logic    err;
        err = line_ovf;
        case (scan_st)
            SCAN_WORD: push_token(TOK_WORD, tok_start, line_pos - tok_start);
            SCAN_GT:   push_token(TOK_OUT, tok_start, POS_W'(1));
            SCAN_LT:   push_token(TOK_IN, tok_start, POS_W'(1));
            SCAN_SQ, SCAN_DQ: err = 1'b1;   // open quote: span dropped
            default: ;
        endcase
        r.token_type   = TOK_LINE_END;
        r.token_start  = line_pos[OFS_W-1:0];
        r.token_length = '0;
        r.quote_state  = QUOTE_NONE;
        r.line_error   = err;
        r.last_of_run  = 1'b0;
        pending_tokens.push_back(r);
        beat_tokens++;
        clear_line_state();
    endfunction

    function automatic void predict_beat(input logic kind, input logic [7:0] b);
        t_result r;
        beat_tokens = 0;
        if (kind == KIND_BYTE)
            take_line_byte(b);
        else
            take_line_end();
        if (beat_tokens > 0) begin
            r = pending_tokens.pop_back();
            r.last_of_run = 1'b1;
            pending_tokens.push_back(r);
        end
    endfunction

    // ------------------------------------------------------------------------
    // output side: stall pattern and checker
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        case (rx_style)
            RX_RANDOM: out_ch.ready <= ($urandom_range(0, 3) != 0);
            RX_RUNS: begin
                if (rx_run == 0) begin
                    rx_run   = $urandom_range(1, 12);
                    rx_level = ($urandom_range(0, 2) != 0);
                end
                rx_run--;
                out_ch.ready <= rx_level;
            end
            default: out_ch.ready <= 1'b1;
        endcase
    end

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            got_tok.token_type   = out_ch.token_type;
            got_tok.token_start  = out_ch.token_start;
            got_tok.token_length = out_ch.token_length;
            got_tok.quote_state  = out_ch.quote_state;
            got_tok.line_error   = out_ch.line_error;
            got_tok.last_of_run  = out_ch.last_of_run;
            if (pending_tokens.size() == 0) begin
                $display("%0t: unexpected token beat, expected none actual type %0d start %0d",
                         $time, got_tok.token_type, got_tok.token_start);
                error_count++;
            end else begin
                want_tok = pending_tokens.pop_front();
                check_field("token_type",   want_tok.token_type,   got_tok.token_type);
                check_field("token_start",  want_tok.token_start,  got_tok.token_start);
                check_field("token_length", want_tok.token_length, got_tok.token_length);
                check_field("quote_state",  want_tok.quote_state,  got_tok.quote_state);
                check_field("line_error",   want_tok.line_error,   got_tok.line_error);
                check_field("last_of_run",  want_tok.last_of_run,  got_tok.last_of_run);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d tokens pending", cycle_count,
                     pending_tokens.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------------
    // called at a falling edge, returns at a falling edge; valid stays up
    // between back-to-back beats
    task automatic send_beat(input logic kind, input logic [7:0] b);
        if (tx_bursty) begin
            if (burst_left == 0) begin
                in_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
                burst_left = $urandom_range(1, 16);
            end
            burst_left--;
        end
        in_ch.valid     <= 1'b1;
        in_ch.kind      <= kind;
        in_ch.char_byte <= b;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        predict_beat(kind, b);
        beats_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_beat(KIND_BYTE, s[i]);
    endtask

    task automatic send_line_end();
        send_beat(KIND_END, 8'($urandom_range(0, 255)));
    endtask

    task automatic drain_tokens();
        in_ch.valid <= 1'b0;
        while (pending_tokens.size() != 0)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic set_pacing(input bit bursty, input int rx);
        tx_bursty  = bursty;
        burst_left = 0;
        rx_style   = rx;
    endtask

    function automatic logic [7:0] rand_plain_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (!plain_byte(b));
        return b;
    endfunction

    function automatic logic [7:0] rand_sep_byte();
        case ($urandom_range(0, 5))
            0: return CH_SPACE;
            1: return CH_DOLLAR;
            2: return CH_NUL;
            default: return 8'($urandom_range(9, 13));
        endcase
    endfunction

    task automatic send_word(input int n);
        repeat (n) send_beat(KIND_BYTE, rand_plain_byte());
    endtask

    task automatic send_quoted(input logic [7:0] q, input bit closed);
        logic [7:0] b;
        send_beat(KIND_BYTE, q);
        repeat ($urandom_range(0, 5)) begin
            do b = 8'($urandom_range(0, 255)); while (b == q);
            send_beat(KIND_BYTE, b);
        end
        if (closed)
            send_beat(KIND_BYTE, q);
    endtask

    // mostly well-formed command lines with random content
    task automatic send_random_line();
        logic [7:0] r;
        repeat ($urandom_range(1, 8)) begin
            case ($urandom_range(0, 9))
                0, 1, 2: send_word($urandom_range(1, 6));
                3: send_beat(KIND_BYTE, CH_PIPE);
                4, 5: begin
                    r = $urandom_range(0, 1) ? CH_GT : CH_LT;
                    send_beat(KIND_BYTE, r);
                    if ($urandom_range(0, 1))
                        send_beat(KIND_BYTE, r);
                    if ($urandom_range(0, 1))
                        send_beat(KIND_BYTE, rand_sep_byte());
                    if ($urandom_range(0, 4) != 0)
                        send_word($urandom_range(1, 4));
                end
                6, 7: send_quoted($urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE, 1'b1);
                8: repeat ($urandom_range(1, 3)) send_beat(KIND_BYTE, rand_sep_byte());
                default: send_beat(KIND_BYTE, 8'($urandom_range(0, 255)));
            endcase
            if ($urandom_range(0, 2) != 0)
                send_beat(KIND_BYTE, rand_sep_byte());
        end
        if ($urandom_range(0, 9) == 0)
            send_quoted($urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE, 1'b0);
        send_line_end();
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_directed_tokens();
        set_pacing(1'b0, RX_ALWAYS);
        send_line_end();                        // empty line
        send_text(">>x<");                      // append, target, in left open at end
        send_line_end();
        send_text("''");                        // empty quotes, quote mode persists
        send_beat(KIND_BYTE, 8'd10);
        send_beat(KIND_BYTE, 8'd11);
        send_text("\"\"");
        send_beat(KIND_BYTE, 8'd12);
        send_beat(KIND_BYTE, 8'd13);
        send_line_end();
        send_text("<>");                        // redirection as redirection target
        send_beat(KIND_BYTE, 8'hFF);
        send_beat(KIND_BYTE, CH_NUL);
        send_beat(KIND_BYTE, 8'd8);
        send_beat(KIND_BYTE, CH_PIPE);          // word then pipe on one beat
        send_beat(KIND_BYTE, 8'd14);
        send_beat(KIND_BYTE, CH_GT);
        send_line_end();
        send_text("\"b\"c'");                   // double quote state, then open quote
        send_line_end();
        send_text("$");
        send_beat(KIND_BYTE, 8'd9);
        send_text("<<q");                       // heredoc limiter
        send_line_end();
        drain_tokens();
    endtask

    task automatic test_random_lines();
        int stop_at;
        int line_no;
        stop_at = beats_sent + 700;
        line_no = 0;
        while (beats_sent < stop_at) begin
            if (line_no % 10 == 0)
                set_pacing((line_no / 10) % 4 != 0, (line_no / 10) % 3);
            send_random_line();
            line_no++;
            if (line_no == 20)
                drain_tokens();
        end
        drain_tokens();
    endtask

    task automatic test_noise_bytes();
        set_pacing(1'b1, RX_RUNS);
        repeat (300) begin
            if ($urandom_range(0, 19) == 0)
                send_line_end();
            else
                send_beat(KIND_BYTE, 8'($urandom_range(0, 255)));
        end
        send_line_end();
        drain_tokens();
    endtask

    // one long word closed by an open redirection at line end
    task automatic test_long_line();
        set_pacing(1'b0, RX_RANDOM);
        repeat (160) send_beat(KIND_BYTE, rand_plain_byte());
        send_beat(KIND_BYTE, CH_GT);
        send_line_end();
        drain_tokens();
    endtask

    initial begin
        in_ch.valid     = 1'b0;
        in_ch.kind      = KIND_BYTE;
        in_ch.char_byte = 8'h00;
        out_ch.ready    = 1'b0;
        i_rst_n         = 1'b0;
        error_count     = 0;
        cycle_count     = 0;
        beats_sent      = 0;
        rx_run          = 0;
        rx_level        = 1'b1;
        set_pacing(1'b0, RX_ALWAYS);
        clear_line_state();

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed_tokens();
        test_random_lines();
        test_noise_bytes();
        test_long_line();

        drain_tokens();
        repeat (8) @(posedge i_clk);
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/slt_pkg.sv
hdl/slt_if.sv
hdl/slt_step.sv
hdl/slt_res_fifo.sv
hdl/shell_line_tokenizer_core.sv
tb/sv/tb_shell_line_tokenizer_core.sv
